// ----- hdl/joystick_average_and_map_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the joystick average and map core
// Shared property forms used by the controller's checks.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AVERAGE_AND_MAP_CORE_ASSERT_SVH
`define JOYSTICK_AVERAGE_AND_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define JAM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define JAM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/jam_pkg.sv -----
// ----------------------------------------------------------------------------
// jam_pkg
// Types, constants and codes shared by the joystick average and map core.
// ----------------------------------------------------------------------------
package jam_pkg;

   localparam int DEPTH_DEF   = 8;
   localparam int SAMPLE_W    = 12;
   localparam int CODE_W      = 13;
   localparam int DEAD_W      = 15;
   localparam int POS_W       = 16;
   localparam int FRAC_STEPS  = 15;
   // Remainder holds twice the largest divisor (13-bit magnitude).
   localparam int REM_W       = 14;
   localparam int DSR_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CODE_W-1:0]   CODE_UNSET = {CODE_W{1'b1}};
   localparam logic [DEAD_W-1:0]   FULL_SCALE = {DEAD_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER = 2'd0,
      CSR_MIN    = 2'd1,
      CSR_MAX    = 2'd2,
      CSR_DEAD   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVERAGE,
      ST_MAP_LOAD,
      ST_MAP_DIV,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // capture the sample and read the oldest ring entry
      logic update;    // update sum and ring
      logic average;   // form the average code from the running sum
      logic step;      // one restoring-division step of the mapping divide
      logic map_load;  // set up the mapping divide
      logic out_load;  // load the result register
   } cmd_type;

endpackage

// ----- hdl/jam_ram.sv -----
// ----------------------------------------------------------------------------
// jam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jam_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/jam_datapath.sv -----
// ----------------------------------------------------------------------------
// jam_datapath
// Sample ring, running sum, average, serial mapping divider and result register.
// ----------------------------------------------------------------------------
module jam_datapath #(
   parameter int DEPTH = jam_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  jam_pkg::cmd_type                   cmd,
   input  logic [jam_pkg::SAMPLE_W-1:0]       sample,
   input  logic                               csr_write,
   input  logic [jam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jam_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic signed [jam_pkg::POS_W-1:0]   position,
   output logic [jam_pkg::SAMPLE_W-1:0]       average_code,
   output logic                               valid_res
);

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int SUM_W     = jam_pkg::SAMPLE_W + IDX_W;
   // Reciprocal of DEPTH rounded up. With this shift the product gives
   // floor(sum / DEPTH) exactly for every sum that fits in SUM_W bits.
   localparam int AVG_SHIFT = SUM_W + IDX_W;
   localparam int RECIP_W   = SUM_W + 1;
   localparam int RECIP     = ((1 << AVG_SHIFT) + DEPTH - 1) / DEPTH;
   // The average never exceeds the largest code, so the product fits here.
   localparam int PROD_W    = AVG_SHIFT + jam_pkg::SAMPLE_W;
   localparam int QUO_W     = jam_pkg::FRAC_STEPS;
   localparam int REM_W     = jam_pkg::REM_W;
   localparam int DSR_W     = jam_pkg::DSR_W;
   localparam int CW        = jam_pkg::CODE_W;

   // Configuration registers.
   logic [CW-1:0]               center_ff, min_ff, max_ff;
   logic [jam_pkg::DEAD_W-1:0]  dead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= jam_pkg::CODE_UNSET;
         min_ff    <= jam_pkg::CODE_UNSET;
         max_ff    <= jam_pkg::CODE_UNSET;
         dead_ff   <= '0;
      end else if (csr_write) begin
         case (jam_pkg::csr_index_type'(csr_index))
            jam_pkg::CSR_CENTER: center_ff <= csr_data[CW-1:0];
            jam_pkg::CSR_MIN:    min_ff    <= csr_data[CW-1:0];
            jam_pkg::CSR_MAX:    max_ff    <= csr_data[CW-1:0];
            jam_pkg::CSR_DEAD:   dead_ff   <= csr_data[jam_pkg::DEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Ring of samples: the RAM holds the data, one valid bit per entry stands
   // in for the cleared state after reset.
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic [DEPTH-1:0]              ring_vld_ff;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [jam_pkg::SAMPLE_W-1:0]  sample_ff;
   logic [jam_pkg::SAMPLE_W-1:0]  rd_data;
   logic [jam_pkg::SAMPLE_W-1:0]  old_sample;

   jam_ram #(
      .WIDTH (jam_pkg::SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign old_sample = ring_vld_ff[slot_ff] ? rd_data : '0;
   assign sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
   assign slot_in    = (slot_ff == IDX_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         ring_vld_ff <= '0;
         sum_ff      <= '0;
      end else if (cmd.update) begin
         slot_ff              <= slot_in;
         ring_vld_ff[slot_ff] <= 1'b1;
         sum_ff               <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample;
      end
   end

   // Average code: the registered sum times the reciprocal of DEPTH.
   logic [PROD_W-1:0]            avg_prod;
   logic [jam_pkg::SAMPLE_W-1:0] avg_ff;

   assign avg_prod = sum_ff * RECIP_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.average) begin
         avg_ff <= avg_prod[AVG_SHIFT +: jam_pkg::SAMPLE_W];
      end
   end

   // Mapping set-up: signed offsets from the center and the branch divisor.
   logic signed [REM_W-1:0] avg_s, c_s, lo_s, hi_s, num_s, den_s;
   logic [DSR_W-1:0]        an, ad;
   logic                    above;

   assign avg_s = $signed({{(REM_W - jam_pkg::SAMPLE_W){1'b0}}, avg_ff});
   assign c_s   = $signed({center_ff[CW-1], center_ff});
   assign lo_s  = $signed({min_ff[CW-1], min_ff});
   assign hi_s  = $signed({max_ff[CW-1], max_ff});
   assign above = (avg_s >= c_s);
   assign num_s = avg_s - c_s;
   assign den_s = above ? (hi_s - c_s) : (c_s - lo_s);
   assign an    = num_s[REM_W-1] ? DSR_W'(-num_s) : num_s[DSR_W-1:0];
   assign ad    = den_s[REM_W-1] ? DSR_W'(-den_s) : den_s[DSR_W-1:0];

   logic                         above_ff, neg_ff, zero_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.map_load) begin
         above_ff <= above;
         neg_ff   <= num_s[REM_W-1] ^ den_s[REM_W-1];
         zero_ff  <= (den_s == '0);
         sat_ff   <= (an >= ad);
      end
   end

   // Restoring divider for the mapping. The remainder starts at the offset
   // magnitude and zeros are shifted in, which gives the quotient bits of
   // offset * 2^15 / divisor.
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] shifted;
   logic [REM_W:0]   trial;

   assign shifted = {rem_ff[REM_W-2:0], 1'b0};
   assign trial   = {1'b0, shifted} - {{(REM_W + 1 - DSR_W){1'b0}}, dsr_ff};

   always_comb begin
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      if (cmd.map_load) begin
         rem_in = REM_W'(an);
         dsr_in = ad;
         quo_in = '0;
      end else if (cmd.step) begin
         rem_in = trial[REM_W] ? shifted : trial[REM_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ~trial[REM_W]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   // Final position: saturation, sign, deadzone and calibration check.
   logic [jam_pkg::DEAD_W-1:0]      mag;
   logic signed [jam_pkg::POS_W-1:0] pos_mag, pos_res;
   logic                            calibrated;

   assign calibrated = (center_ff != jam_pkg::CODE_UNSET) &&
                       (min_ff != jam_pkg::CODE_UNSET) &&
                       (max_ff != jam_pkg::CODE_UNSET);

   always_comb begin
      if (zero_ff || sat_ff) begin
         mag = jam_pkg::FULL_SCALE;
      end else begin
         mag = quo_ff;
      end
      pos_mag = $signed({1'b0, mag});
      if (zero_ff ? !above_ff : neg_ff) begin
         pos_res = -pos_mag;
      end else begin
         pos_res = pos_mag;
      end
      if (!calibrated || (mag < dead_ff)) begin
         pos_res = '0;
      end
   end

   logic signed [jam_pkg::POS_W-1:0] pos_out_ff;
   logic [jam_pkg::SAMPLE_W-1:0]     avg_out_ff;
   logic                             vld_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pos_out_ff <= pos_res;
         avg_out_ff <= avg_ff;
         vld_out_ff <= calibrated;
      end
   end

   assign position     = pos_out_ff;
   assign average_code = avg_out_ff;
   assign valid_res    = vld_out_ff;

endmodule

// ----- hdl/jam_ctrl.sv -----
// ----------------------------------------------------------------------------
// jam_ctrl
// Sequencer for one item: ring update, average, mapping divide, result.
// ----------------------------------------------------------------------------
`include "joystick_average_and_map_core_assert.svh"

module jam_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output jam_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(jam_pkg::FRAC_STEPS + 1);

   jam_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jam_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         jam_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = jam_pkg::ST_UPDATE;
            end
         end
         jam_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = jam_pkg::ST_AVERAGE;
         end
         jam_pkg::ST_AVERAGE: begin
            cmd.average = 1'b1;
            state_in    = jam_pkg::ST_MAP_LOAD;
         end
         jam_pkg::ST_MAP_LOAD: begin
            cmd.map_load = 1'b1;
            cnt_in       = '0;
            state_in     = jam_pkg::ST_MAP_DIV;
         end
         jam_pkg::ST_MAP_DIV: begin
            cmd.step = 1'b1;
            if (cnt_ff == CNT_W'(jam_pkg::FRAC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = jam_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         jam_pkg::ST_FINISH: begin
            // The result register is free once its item has been taken.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = jam_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jam_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `JAM_ASSERT_NXT(a_accept_starts_update, clock, reset, req_tvalid && req_tready,
      state_ff == jam_pkg::ST_UPDATE, "accepted item did not start an update")
   `JAM_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == jam_pkg::ST_FINISH, "result appeared outside the finish step")
   `JAM_ASSERT_IMP(a_map_count_bound, clock, reset, state_ff == jam_pkg::ST_MAP_DIV,
      cnt_ff < CNT_W'(jam_pkg::FRAC_STEPS), "mapping divide ran past its step count")
   `JAM_ASSERT_NXT(a_finish_holds, clock, reset,
      state_ff == jam_pkg::ST_FINISH && rsp_valid_ff && !rsp_tready,
      state_ff == jam_pkg::ST_FINISH && rsp_valid_ff, "finished item overwrote a waiting result")

endmodule

// ----- hdl/joystick_average_and_map_core.sv -----
// ----------------------------------------------------------------------------
// joystick_average_and_map_core
// Moving average of a joystick ADC axis, mapped to a signed Q1.15 position.
// ----------------------------------------------------------------------------
// Usage: each item on the req_ channel carries one 12-bit ADC sample. It is
// written into a ring of DEPTH samples, the running sum gives the average
// code, and the average is mapped against the center, min and max codes into
// a clamped, deadzoned Q1.15 position. Every input item yields exactly one
// item on the rsp_ channel.
// Configuration is written through the csr_ channel (index 0 center, 1 min,
// 2 max, 3 dead band) while the block is idle; csr_ready is always high.
// Sequence: after the edge that accepts an item, for any DEPTH, the block
// updates the ring and sum, forms the average (the sum times the reciprocal
// of DEPTH), sets up the mapping, runs the serial restoring divider that
// forms the fraction bits, and loads the result register. req_tready returns
// as that register is loaded, so the block takes no new item while one is
// still in flight.
// Reset: the ring reads as all zero, the sum and write slot are cleared and
// the calibration codes read as unset, so results carry valid_res 0 until all three are written.
// Stall: a result waits in the output register while rsp_tready is low; the
// next item is still accepted, completes its computation and holds until
// that register frees up.
// ----------------------------------------------------------------------------
module joystick_average_and_map_core #(
   parameter int DEPTH = jam_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sample stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [jam_pkg::REQ_DATA_W-1:0]    req_tdata,   // [11:0] sample
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [jam_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] position, [27:16] average_code
   output logic                              rsp_tuser,   // [0] valid_res
   // Configuration writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jam_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jam_pkg::CSR_DATA_W-1:0]    csr_data
);

   jam_pkg::cmd_type                  cmd;
   logic signed [jam_pkg::POS_W-1:0]  position;
   logic [jam_pkg::SAMPLE_W-1:0]      average_code;
   logic                              valid_res;

   // Configuration writes are always taken; the host issues them only while
   // no item is in flight.
   assign csr_ready = 1'b1;

   jam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   jam_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample       (req_tdata[jam_pkg::SAMPLE_W-1:0]),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .position     (position),
      .average_code (average_code),
      .valid_res    (valid_res)
   );

   // Pack the result: position lowest, then the average code, zero padding.
   assign rsp_tdata = {
      {(jam_pkg::RSP_DATA_W - jam_pkg::POS_W - jam_pkg::SAMPLE_W){1'b0}},
      average_code,
      position
   };
   assign rsp_tuser = valid_res;

endmodule

// ----- dv/joystick_average_and_map_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_average_and_map_core_tb
// Self-checking bench for the joystick average and map core. Samples stream
// in through req_, and each one is predicted against a ring of eight codes
// and the calibration registers. Each result on rsp_ is checked field by
// field, across several calibration settings.
// ----------------------------------------------------------------------------
module joystick_average_and_map_core_tb;
   import jam_pkg::*;

   localparam int CLK_PERIOD = 10;
   localparam int RING_DEPTH = DEPTH_DEF;
   // This wait covers a full pass of one item through the core.
   localparam int SETTLE_CYCLES = 40;
   // About 760 items. At worst each one sees the longest receiver stall, the
   // longest sender gap and its own pass through the core, plus the idle waits
   // between phases. The limit is several times that.
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic signed [POS_W-1:0]    position;
      logic [SAMPLE_W-1:0]        average_code;
      logic                       valid_res;
   } axis_result_type;

   // Ports of the core. Each input has a known value from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Mirror of the core's state and registers, as they stand after reset.
   logic [SAMPLE_W-1:0]    ring_codes [RING_DEPTH] = '{default: '0};
   int                     next_slot = 0;
   int                     code_sum = 0;
   logic signed [CODE_W-1:0] center_cfg = CODE_UNSET;
   logic signed [CODE_W-1:0] min_cfg = CODE_UNSET;
   logic signed [CODE_W-1:0] max_cfg = CODE_UNSET;
   logic [DEAD_W-1:0]      dead_cfg = '0;

   logic [SAMPLE_W-1:0]    pending_samples [$];
   axis_result_type        expected_positions [$];
   int                     samples_queued = 0;
   int                     results_checked = 0;
   int                     mismatch_count = 0;
   int                     cycle_count = 0;

   // Sender burst state and receiver stall state.
   int                     burst_left = 0;
   int                     gap_left = 0;
   int                     ready_hold = 0;
   int                     rx_mode = 0;
   logic                   ready_next;

   joystick_average_and_map_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Push one sample into the ring mirror and work out the result it causes.
   // Positions go below center as (avg-center)/(center-min), and at or above
   // center as (avg-center)/(max-center), in Q1.15. A divisor of zero gives
   // full scale in the direction of the branch. A divisor that is negative
   // (reversed calibration) is taken as is, so the sign follows it.
   function automatic axis_result_type average_and_map(logic [SAMPLE_W-1:0] sample);
      axis_result_type r;
      int avg, c, lo, hi, num, den, mag, pos;
      bit above;
      code_sum = code_sum - int'(ring_codes[next_slot]) + int'(sample);
      ring_codes[next_slot] = sample;
      next_slot = (next_slot + 1) % RING_DEPTH;
      avg = code_sum / RING_DEPTH;
      c = center_cfg;
      lo = min_cfg;
      hi = max_cfg;
      r.average_code = avg[SAMPLE_W-1:0];
      // Any code other than the unset marker counts as calibrated, even a
      // negative one.
      r.valid_res = (center_cfg != CODE_UNSET) && (min_cfg != CODE_UNSET) &&
                    (max_cfg != CODE_UNSET);
      pos = 0;
      if (r.valid_res) begin
         above = (avg >= c);
         num = avg - c;
         den = above ? hi - c : c - lo;
         if (den == 0) begin
            mag = int'(FULL_SCALE);
            pos = above ? mag : -mag;
         end else begin
            mag = ((num < 0 ? -num : num) << FRAC_STEPS) / (den < 0 ? -den : den);
            if (mag > int'(FULL_SCALE)) mag = int'(FULL_SCALE);
            pos = ((num < 0) != (den < 0)) ? -mag : mag;
         end
         // The deadzone acts on the clamped magnitude.
         if (mag < int'(dead_cfg)) pos = 0;
      end
      r.position = pos[POS_W-1:0];
      return r;
   endfunction

   // Sender. Samples leave the pending queue in bursts of random length with
   // random gaps; a sample on the bus stays there until the core takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_positions.push_back(average_and_map(req_tdata[SAMPLE_W-1:0]));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {{(REQ_DATA_W-SAMPLE_W){1'b0}}, pending_samples.pop_front()};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
                                                           : $urandom_range(10, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker. Readiness follows a pattern that rotates with the
   // cycle count: always ready, short random stalls, then long stalls that
   // keep a finished item waiting while the next one completes behind it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_positions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result with no item outstanding: data %h user %b",
                           rsp_tdata, rsp_tuser);
            end else begin
               automatic axis_result_type want = expected_positions.pop_front();
               if (rsp_tdata[15:0] !== want.position ||
                   rsp_tdata[27:16] !== want.average_code ||
                   rsp_tuser !== want.valid_res) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch on result %0d: position exp %0d got %0d, ",
                               "average_code exp %0d got %0d, valid_res exp %b got %b"},
                              results_checked, want.position, $signed(rsp_tdata[15:0]),
                              want.average_code, rsp_tdata[27:16], want.valid_res,
                              rsp_tuser);
               end
            end
         end
         rx_mode = (cycle_count / 700) % 3;
         if (ready_hold > 0) begin
            ready_hold--;
         end else begin
            case (rx_mode)
               0: begin
                  ready_next = 1'b1;
                  ready_hold = 16;
               end
               1: begin
                  ready_next = ($urandom_range(0, 2) != 0);
                  ready_hold = $urandom_range(0, 3);
               end
               default: begin
                  ready_next = !rsp_tready;
                  ready_hold = ready_next ? $urandom_range(1, 10) : $urandom_range(10, 60);
               end
            endcase
            rsp_tready <= ready_next;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results checked", cycle_count,
                  results_checked);
         $display("joystick_average_and_map_core_tb: FAIL");
         $finish;
      end
   end

   // Register write through the csr channel. The mirror takes the new value
   // at the same edge as the core.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CENTER: center_cfg = value[CODE_W-1:0];
         CSR_MIN:    min_cfg = value[CODE_W-1:0];
         CSR_MAX:    max_cfg = value[CODE_W-1:0];
         CSR_DEAD:   dead_cfg = value[DEAD_W-1:0];
         default: ;
      endcase
   endtask

   // The bits above a 13-bit code are random, since the core must drop them.
   task automatic write_calibration(int c, int lo, int hi, int dead);
      write_reg(CSR_CENTER, {2'($urandom), c[CODE_W-1:0]});
      write_reg(CSR_MIN, {2'($urandom), lo[CODE_W-1:0]});
      write_reg(CSR_MAX, {2'($urandom), hi[CODE_W-1:0]});
      write_reg(CSR_DEAD, dead[DEAD_W-1:0]);
   endtask

   task automatic queue_sample(int code);
      pending_samples.push_back(code[SAMPLE_W-1:0]);
      samples_queued++;
   endtask

   // Stick motion: the stick is held near a target for a few samples, so the
   // moving average sweeps the whole range, with some single noisy readings.
   task automatic queue_stick_motion(int count);
      int target, run;
      while (count > 0) begin
         case ($urandom_range(0, 9))
            0: target = 0;
            1: target = 4095;
            2: target = $urandom_range(0, 4095);
            default: target = int'(center_cfg) + $urandom_range(0, 800) - 400;
         endcase
         run = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 12);
         repeat (run) begin
            if (count > 0) begin
               if ($urandom_range(0, 6) == 0)
                  queue_sample($urandom_range(0, 4095));
               else
                  queue_sample((target + $urandom_range(0, 40) - 20) & 12'hFFF);
               count--;
            end
         end
      end
   endtask

   // The sender holds off here until every result is back, so the core is
   // idle before the registers change.
   task automatic wait_for_idle();
      while (results_checked < samples_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_calibration();
      int c, lo, hi, dead;
      c = $urandom_range(0, 4095);
      lo = $urandom_range(0, c);
      hi = $urandom_range(c, 4095);
      case ($urandom_range(0, 7))
         0: lo = c;
         1: hi = c;
         2: begin
            lo = $urandom_range(0, 4095);
            hi = $urandom_range(0, 4095);
         end
         3: lo = -int'($urandom_range(1, 4096));
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: dead = 0;
         1: dead = $urandom_range(0, 32767);
         2: dead = 32767;
         default: dead = $urandom_range(0, 4000);
      endcase
      write_calibration(c, lo, hi, dead);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Not calibrated yet: position stays zero while the average still
      // moves. The ring fills with full-scale codes, then alternating bits.
      repeat (8) queue_sample(4095);
      queue_sample(0);
      queue_sample(12'hAAA);
      queue_sample(12'h555);
      queue_stick_motion(40);
      wait_for_idle();

      // Normal calibration over the full range. Eight zeros take the average
      // to the bottom code, which equals the min code, so the position clamps.
      write_calibration(2048, 0, 4095, 0);
      repeat (8) queue_sample(0);
      queue_stick_motion(120);
      wait_for_idle();

      // Both spans are zero, so any deflection is full scale.
      write_calibration(2000, 2000, 2000, 0);
      queue_stick_motion(60);
      wait_for_idle();

      // Reversed calibration: max below center and min above it.
      write_calibration(1000, 3000, 200, 1000);
      queue_stick_motion(80);
      wait_for_idle();

      // Negative codes other than the unset marker, with the widest deadzone.
      write_calibration(-4096, -2, 4095, 32767);
      queue_stick_motion(80);
      wait_for_idle();

      // Only partly calibrated: a single unset code keeps the result invalid.
      write_calibration(2048, -1, 4095, 0);
      queue_stick_motion(40);
      wait_for_idle();

      repeat (6) begin
         random_calibration();
         queue_stick_motion(55);
         wait_for_idle();
      end

      if (expected_positions.size() != 0) begin
         mismatch_count += expected_positions.size();
         $display("%0d results never arrived", expected_positions.size());
      end
      if (mismatch_count == 0) begin
         $display("joystick_average_and_map_core_tb: PASS");
      end else begin
         $display("joystick_average_and_map_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/jam_pkg.sv
hdl/jam_ram.sv
hdl/jam_datapath.sv
hdl/jam_ctrl.sv
hdl/joystick_average_and_map_core.sv
dv/joystick_average_and_map_core_tb.sv
